>>> sv/csp_pkg.sv
// Shared types and constants for the centripetal spline position evaluator.
package csp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int RATIO_BITS      = 30;

    localparam logic OPC_PUSH = 1'b0;
    localparam logic OPC_EVAL = 1'b1;

    // Operations of the shared iterative unit.
    typedef enum logic [2:0] {
        OP_MUL,
        OP_MUL_R,
        OP_MUL_T,
        OP_SQRT,
        OP_DIV
    } t_op;

    // Working width of one operand of the shared unit.
    function automatic int f_mw(input int cw);
        return (cw + 2 > RATIO_BITS + 2) ? cw + 2 : RATIO_BITS + 2;
    endfunction

endpackage

>>> sv/centripetal_spline_position_eval_top.sv
// Top level: control window, sequencer and result stage of the spline evaluator.
// Push: shifts the window, no result. Evaluate: one result per transfer, where
// MW = max(COORD_WIDTH, 30) + 2 is the working width of the shared unit.
// The shared radix-2 unit does the work at one bit per cycle for each of 32 multiplies,
// 6 square roots and 4 divisions (double-width quotient each), run back to back.
// Synchronous active-low reset clears the window to zero and empties the result stage.
module centripetal_spline_position_eval_top import csp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic [T_FRAC_BITS:0]          i_local_t,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_pos_z
);

    localparam int CW = COORD_WIDTH;
    localparam int MW = f_mw(COORD_WIDTH);
    localparam int AW = 2 * MW;
    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic signed [AW-1:0] SAT_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_LOAD} t_state;
    typedef enum logic [1:0] {PH_CHORD, PH_DIV, PH_CUBE, PH_BLEND} t_phase;

    // Window points, packed as {z, y, x}; r_p3 is the newest.
    logic [3*CW-1:0] r_p0, r_p1, r_p2, r_p3;

    t_state r_state;
    t_phase r_phase;
    logic [1:0] r_idx;
    logic [2:0] r_sub;

    logic signed [AW-1:0] r_acc;
    logic [MW-1:0] r_d0, r_d1, r_d2;
    logic [MW-1:0] r_wa, r_wb, r_wc, r_we;
    logic [MW-1:0] r_u, r_u2, r_u3;
    logic signed [MW-1:0] r_m1, r_m2;
    logic signed [CW-1:0] r_sx, r_sy, r_sz;
    logic r_ovalid;
    logic signed [CW-1:0] r_ox, r_oy, r_oz;

    t_op           s_op;
    logic [AW-1:0] s_a;
    logic [MW-1:0] s_b;
    logic          u_done;
    logic signed [AW-1:0] u_res;

    logic [3*CW-1:0] s_pa, s_pb;
    logic signed [MW-1:0] s_cdiff;
    logic signed [MW-1:0] s_bp1, s_v10, s_v21, s_v32;
    logic signed [MW-1:0] s_h2, s_h3, s_h4;
    logic [MW-1:0] s_den01, s_den12;
    logic [MW-1:0] s_den;
    logic signed [AW-1:0] s_sum;
    logic signed [CW-1:0] s_sat;
    logic s_in_xfer;

    function automatic logic signed [MW-1:0] f_axis(input logic [3*CW-1:0] p,
                                                    input logic [1:0] ax);
        logic [CW-1:0] v;
        unique case (ax)
            2'd1:    v = p[2*CW-1:CW];
            2'd2:    v = p[3*CW-1:2*CW];
            default: v = p[CW-1:0];
        endcase
        return {{(MW-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic [AW-1:0] f_sext(input logic [MW-1:0] v);
        return {{MW{v[MW-1]}}, v};
    endfunction

    assign o_stall   = (r_state != S_IDLE);
    assign s_in_xfer = i_valid && !o_stall;

    // Chord endpoints for the square-sum steps.
    always_comb begin
        unique case (r_idx)
            2'd1:    begin s_pa = r_p1; s_pb = r_p2; end
            2'd2:    begin s_pa = r_p2; s_pb = r_p3; end
            default: begin s_pa = r_p0; s_pb = r_p1; end
        endcase
        s_cdiff = f_axis(s_pb, r_sub[1:0]) - f_axis(s_pa, r_sub[1:0]);
    end

    // Blend operands for the axis in work.
    always_comb begin
        s_bp1 = f_axis(r_p1, r_idx);
        s_v10 = s_bp1 - f_axis(r_p0, r_idx);
        s_v21 = f_axis(r_p2, r_idx) - s_bp1;
        s_v32 = f_axis(r_p3, r_idx) - f_axis(r_p2, r_idx);
        s_h2  = MW'(3 * r_u2) - MW'(2 * r_u3);
        s_h3  = r_u3 - MW'(2 * r_u2) + r_u;
        s_h4  = r_u3 - r_u2;
        s_den01 = r_d0 + r_d1;
        s_den12 = r_d1 + r_d2;
    end

    // Operand selection for the next unit operation.
    always_comb begin
        s_op  = OP_MUL;
        s_a   = '0;
        s_b   = '0;
        s_den = s_den01;
        unique case (r_phase)
            PH_CHORD: begin
                priority if (r_sub == 3'd3) begin
                    s_op = OP_SQRT;
                    s_a  = r_acc;
                end else if (r_sub == 3'd4) begin
                    s_op = OP_SQRT;
                    s_a  = r_acc << 16;
                end else begin
                    s_op = OP_MUL;
                    s_a  = f_sext(s_cdiff);
                    s_b  = s_cdiff;
                end
            end
            PH_DIV: begin
                s_op = OP_DIV;
                unique case (r_sub[1:0])
                    2'd0:    begin s_a = {{MW{1'b0}}, r_d1} << RATIO_BITS; s_den = s_den01; end
                    2'd1:    begin s_a = {{MW{1'b0}}, r_d0} << RATIO_BITS; s_den = s_den01; end
                    2'd2:    begin s_a = {{MW{1'b0}}, r_d2} << RATIO_BITS; s_den = s_den12; end
                    default: begin s_a = {{MW{1'b0}}, r_d1} << RATIO_BITS; s_den = s_den12; end
                endcase
                s_b = s_den;
            end
            PH_CUBE: begin
                s_op = OP_MUL_T;
                s_a  = f_sext((r_sub == 3'd0) ? r_u : r_u2);
                s_b  = r_u;
            end
            default: begin
                unique case (r_sub)
                    3'd0:    begin s_op = OP_MUL_R; s_a = f_sext(s_v10); s_b = r_wa; end
                    3'd1:    begin s_op = OP_MUL_R; s_a = f_sext(s_v21); s_b = r_wb; end
                    3'd2:    begin s_op = OP_MUL_R; s_a = f_sext(s_v21); s_b = r_wc; end
                    3'd3:    begin s_op = OP_MUL_R; s_a = f_sext(s_v32); s_b = r_we; end
                    3'd4:    begin s_op = OP_MUL_T; s_a = f_sext(s_v21); s_b = s_h2; end
                    3'd5:    begin s_op = OP_MUL_T; s_a = f_sext(r_m1);  s_b = s_h3; end
                    default: begin s_op = OP_MUL_T; s_a = f_sext(r_m2);  s_b = s_h4; end
                endcase
            end
        endcase
    end

    // Accumulate and clamp the blended coordinate.
    always_comb begin
        s_sum = r_acc + u_res;
        priority if (s_sum > SAT_HI) s_sat = SAT_HI[CW-1:0];
        else if (s_sum < SAT_LO)     s_sat = SAT_LO[CW-1:0];
        else                         s_sat = s_sum[CW-1:0];
    end

    csp_iter #(
        .MW (MW),
        .TF (T_FRAC_BITS)
    ) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_ISSUE),
        .i_op     (s_op),
        .i_a      (s_a),
        .i_b      (s_b),
        .o_done   (u_done),
        .o_result (u_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_CHORD;
            r_idx    <= '0;
            r_sub    <= '0;
            r_ovalid <= 1'b0;
            r_p0     <= '0;
            r_p1     <= '0;
            r_p2     <= '0;
            r_p3     <= '0;
        end else begin
            // Drop the result once the far side takes it; the load state handles its own.
            if (r_ovalid && !i_stall && r_state != S_LOAD) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_in_xfer) begin
                        if (i_opcode == OPC_PUSH) begin
                            // Shift the window; the new point enters at the P3 end.
                            r_p0 <= r_p1;
                            r_p1 <= r_p2;
                            r_p2 <= r_p3;
                            r_p3 <= {i_point_z, i_point_y, i_point_x};
                        end else begin
                            r_u     <= MW'((i_local_t > T_ONE) ? T_ONE : i_local_t);
                            r_phase <= PH_CHORD;
                            r_idx   <= '0;
                            r_sub   <= '0;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (u_done) begin
                        r_state <= S_ISSUE;
                        unique case (r_phase)
                            PH_CHORD: begin
                                priority if (r_sub == 3'd0 || r_sub == 3'd3) begin
                                    r_acc <= u_res;
                                end else if (r_sub == 3'd4) begin
                                    unique case (r_idx)
                                        2'd1:    r_d1 <= u_res[MW-1:0];
                                        2'd2:    r_d2 <= u_res[MW-1:0];
                                        default: r_d0 <= u_res[MW-1:0];
                                    endcase
                                end else begin
                                    r_acc <= s_sum;
                                end
                                if (r_sub == 3'd4) begin
                                    r_sub <= '0;
                                    if (r_idx == 2'd2) begin
                                        r_idx   <= '0;
                                        r_phase <= PH_DIV;
                                    end else begin
                                        r_idx <= r_idx + 1'b1;
                                    end
                                end else begin
                                    r_sub <= r_sub + 1'b1;
                                end
                            end
                            PH_DIV: begin
                                // A zero sum of knot steps gives a zero weight.
                                unique case (r_sub[1:0])
                                    2'd0:    r_wa <= (s_den == '0) ? '0 : u_res[MW-1:0];
                                    2'd1:    r_wb <= (s_den == '0) ? '0 : u_res[MW-1:0];
                                    2'd2:    r_wc <= (s_den == '0) ? '0 : u_res[MW-1:0];
                                    default: r_we <= (s_den == '0) ? '0 : u_res[MW-1:0];
                                endcase
                                if (r_sub == 3'd3) begin
                                    r_sub   <= '0;
                                    r_phase <= PH_CUBE;
                                end else begin
                                    r_sub <= r_sub + 1'b1;
                                end
                            end
                            PH_CUBE: begin
                                if (r_sub == 3'd0) begin
                                    r_u2  <= u_res[MW-1:0];
                                    r_sub <= 3'd1;
                                end else begin
                                    r_u3    <= u_res[MW-1:0];
                                    r_sub   <= '0;
                                    r_phase <= PH_BLEND;
                                end
                            end
                            default: begin
                                unique case (r_sub)
                                    3'd0, 3'd2: r_acc <= u_res;
                                    3'd1:       r_m1  <= s_sum[MW-1:0];
                                    3'd3:       r_m2  <= s_sum[MW-1:0];
                                    3'd4:       r_acc <= f_sext(s_bp1) + u_res;
                                    3'd5:       r_acc <= s_sum;
                                    default: begin
                                        unique case (r_idx)
                                            2'd1:    r_sy <= s_sat;
                                            2'd2:    r_sz <= s_sat;
                                            default: r_sx <= s_sat;
                                        endcase
                                    end
                                endcase
                                if (r_sub == 3'd6) begin
                                    r_sub <= '0;
                                    if (r_idx == 2'd2) begin
                                        r_idx   <= '0;
                                        r_state <= S_LOAD;
                                    end else begin
                                        r_idx <= r_idx + 1'b1;
                                    end
                                end else begin
                                    r_sub <= r_sub + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    // Hold the finished point until the output register frees up.
                    if (!r_ovalid || !i_stall) begin
                        r_ox     <= r_sx;
                        r_oy     <= r_sy;
                        r_oz     <= r_sz;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_pos_x = r_ox;
    assign o_pos_y = r_oy;
    assign o_pos_z = r_oz;

    // The shared unit only finishes while the sequencer waits on it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> (r_state == S_WAIT))
        else $error("unit result arrived outside the wait state");

    // A new result only appears from the load state.
    a_rise_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_LOAD))
        else $error("result valid rose without a load");

    // A taken result is cleared unless a fresh one is loaded in the same cycle.
    a_drop_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && r_state != S_LOAD) |=> !o_valid)
        else $error("result repeated after transfer");

    // The sequencer leaves idle only on an input transfer.
    a_issue_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !s_in_xfer) |=> (r_state == S_IDLE))
        else $error("sequencer left idle without an input transfer");

endmodule

>>> sv/csp_iter.sv
// Shared radix-2 unit: shift-add multiply, restoring divide, digit-by-digit square root.
module csp_iter import csp_pkg::*; #(
    parameter int MW = 34,
    parameter int TF = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_op           i_op,
    input  logic [2*MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output logic          o_done,
    output logic [2*MW-1:0] o_result
);

    localparam int AW   = 2 * MW;
    localparam int CNTW = $clog2(AW);

    logic            r_busy;
    logic            r_done;
    t_op             r_op;
    logic [CNTW-1:0] r_cnt;
    logic [AW-1:0]   r_x;
    logic [AW-1:0]   r_q;
    logic [MW+1:0]   r_rem;
    logic [MW-1:0]   r_m;
    logic            r_neg;

    logic [MW-1:0] s_a_lo;
    logic [MW-1:0] s_mag_a;
    logic [MW-1:0] s_mag_b;
    logic [MW:0]   s_mul_sum;
    logic [MW+1:0] s_rs;
    logic [MW+1:0] s_trial;
    logic          s_ge;
    logic [MW+1:0] s_diff;
    logic [AW-1:0] s_mag;
    logic          s_is_sqrt;

    assign s_a_lo  = i_a[MW-1:0];
    assign s_mag_a = s_a_lo[MW-1] ? (~s_a_lo + 1'b1) : s_a_lo;
    assign s_mag_b = i_b[MW-1] ? (~i_b + 1'b1) : i_b;

    assign s_mul_sum = {1'b0, r_x[AW-1:MW]} + (r_x[0] ? {1'b0, r_m} : {(MW+1){1'b0}});
    assign s_is_sqrt = (r_op == OP_SQRT);

    always_comb begin
        if (s_is_sqrt) begin
            s_rs    = {r_rem[MW-1:0], r_x[AW-1:AW-2]};
            s_trial = {r_q[MW-1:0], 2'b01};
        end else begin
            s_rs    = {1'b0, r_rem[MW-1:0], r_x[AW-1]};
            s_trial = {2'b00, r_m};
        end
        s_ge   = (s_rs >= s_trial);
        s_diff = s_rs - s_trial;
    end

    always_comb begin
        unique case (r_op)
            OP_MUL:   s_mag = r_x;
            OP_MUL_R: s_mag = r_x >> RATIO_BITS;
            OP_MUL_T: s_mag = r_x >> TF;
            default:  s_mag = r_q;
        endcase
        o_result = r_neg ? (~s_mag + 1'b1) : s_mag;
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_rem  <= '0;
                r_q    <= '0;
                unique case (i_op)
                    OP_SQRT: begin
                        r_cnt <= CNTW'(MW - 1);
                        r_x   <= i_a;
                        r_neg <= 1'b0;
                    end
                    OP_DIV: begin
                        r_cnt <= CNTW'(AW - 1);
                        r_x   <= i_a;
                        r_m   <= i_b;
                        r_neg <= 1'b0;
                    end
                    default: begin
                        r_cnt <= CNTW'(MW - 1);
                        r_x   <= {{MW{1'b0}}, s_mag_b};
                        r_m   <= s_mag_a;
                        r_neg <= s_a_lo[MW-1] ^ i_b[MW-1];
                    end
                endcase
            end else if (r_busy) begin
                unique case (r_op)
                    OP_SQRT: begin
                        r_x   <= r_x << 2;
                        r_rem <= s_ge ? s_diff : s_rs;
                        r_q   <= {r_q[AW-2:0], s_ge};
                    end
                    OP_DIV: begin
                        r_x   <= r_x << 1;
                        r_rem <= s_ge ? s_diff : s_rs;
                        r_q   <= {r_q[AW-2:0], s_ge};
                    end
                    default: r_x <= {s_mul_sum, r_x[MW-1:1]};
                endcase
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the centripetal spline position evaluator.
module tb;
    import csp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW       = COORD_WIDTH_DEF;
    localparam int TF       = T_FRAC_BITS_DEF;
    localparam int N_ITEMS  = 1150;
    localparam int EVAL_LAT = 2000;   // tail wait after the final drain
    localparam int HOLD_LEN = 5000;
    localparam int IDLE_MAX = 40000;  // cycles with no transfer before giving up

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [TF:0]          param_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } pos_t;

    // Mirror of the control window and the queue of positions still owed.
    class spline_scoreboard;
        longint pts[12];
        pos_t   pos_q[$];
        int     errors;

        function new();
            foreach (pts[i]) pts[i] = 0;
            errors = 0;
        endfunction

        function automatic logic [63:0] isqrt(logic [127:0] n);
            logic [63:0] r, c;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (({64'd0, c} * {64'd0, c}) <= n) r = c;
            end
            return r;
        endfunction

        // product shifted right by s, truncated toward zero, clamped at 64 bits
        function automatic longint scaled_mul(longint a, longint b, int s);
            logic [63:0]  ma, mb, m;
            logic [127:0] p;
            logic         neg;
            neg = (a < 0) != (b < 0);
            ma  = (a < 0) ? -a : a;
            mb  = (b < 0) ? -b : b;
            p   = ({64'd0, ma} * {64'd0, mb}) >> s;
            m   = (p > 128'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : p[63:0];
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function automatic logic [63:0] knot_step(int ia, int ib);
            logic [127:0] sum;
            logic [63:0]  mag, len;
            longint       dv;
            sum = '0;
            for (int ax = 0; ax < 3; ax++) begin
                dv  = pts[3*ib+ax] - pts[3*ia+ax];
                mag = (dv < 0) ? -dv : dv;
                sum += {64'd0, mag} * {64'd0, mag};
            end
            len = isqrt(sum);
            return isqrt({48'd0, len, 16'd0});
        endfunction

        function automatic longint weight(logic [63:0] num, logic [63:0] den);
            if (den == 0) return 0;
            return longint'((num << RATIO_BITS) / den);
        endfunction

        function automatic pos_t eval_position(param_t t_in);
            logic [63:0] d01, d12, d23, tv;
            longint      wa, wb, wc, we, u, u2, u3, h2, h3, h4;
            longint      p0, p1, p2, p3, v10, v21, v32, m1, m2, r;
            longint      hi_lim, lo_lim;
            coord_t      res[3];
            d01 = knot_step(0, 1);
            d12 = knot_step(1, 2);
            d23 = knot_step(2, 3);
            wa  = weight(d12, d01 + d12);
            wb  = weight(d01, d01 + d12);
            wc  = weight(d23, d12 + d23);
            we  = weight(d12, d12 + d23);
            tv  = t_in;
            if (tv > (64'd1 << TF)) tv = 64'd1 << TF;
            u   = tv;
            u2  = (u * u) >>> TF;
            u3  = (u2 * u) >>> TF;
            h2  = 3 * u2 - 2 * u3;
            h3  = u3 - 2 * u2 + u;
            h4  = u3 - u2;
            hi_lim = (longint'(1) <<< (CW - 1)) - 1;
            lo_lim = -hi_lim - 1;
            for (int ax = 0; ax < 3; ax++) begin
                p0  = pts[ax];
                p1  = pts[3+ax];
                p2  = pts[6+ax];
                p3  = pts[9+ax];
                v10 = p1 - p0;
                v21 = p2 - p1;
                v32 = p3 - p2;
                m1  = scaled_mul(v10, wa, RATIO_BITS) + scaled_mul(v21, wb, RATIO_BITS);
                m2  = scaled_mul(v21, wc, RATIO_BITS) + scaled_mul(v32, we, RATIO_BITS);
                r   = p1 + scaled_mul(v21, h2, TF) + scaled_mul(m1, h3, TF)
                    + scaled_mul(m2, h4, TF);
                if (r > hi_lim) r = hi_lim;
                if (r < lo_lim) r = lo_lim;
                res[ax] = r[CW-1:0];
            end
            return '{x: res[0], y: res[1], z: res[2]};
        endfunction

        function void note_input(logic op, coord_t x, coord_t y, coord_t z, param_t t);
            if (op == OPC_PUSH) begin
                for (int i = 0; i < 9; i++) pts[i] = pts[i+3];
                pts[9]  = x;
                pts[10] = y;
                pts[11] = z;
            end else begin
                pos_q = {pos_q, eval_position(t)};
            end
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            if (errors <= 30)
                $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        endtask

        task check_result(coord_t x, coord_t y, coord_t z);
            pos_t e;
            if (pos_q.size() == 0) begin
                report("unexpected position", 1, 0);
                return;
            end
            e = pos_q.pop_front();
            if (x !== e.x) report("pos_x", x, e.x);
            if (y !== e.y) report("pos_y", y, e.y);
            if (z !== e.z) report("pos_z", z, e.z);
        endtask
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    logic   i_opcode = OPC_PUSH;
    coord_t i_point_x = '0;
    coord_t i_point_y = '0;
    coord_t i_point_z = '0;
    param_t i_local_t = '0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    coord_t o_pos_x, o_pos_y, o_pos_z;

    spline_scoreboard sb = new();

    bit     calm;       // stretch with no idling on either side
    bit     hold_req;   // asks the receiver for one long hold-off
    int     items_sent;

    centripetal_spline_position_eval_top #(
        .COORD_WIDTH (CW),
        .T_FRAC_BITS (TF)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_opcode  (i_opcode),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_local_t (i_local_t),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_pos_x   (o_pos_x),
        .o_pos_y   (o_pos_y),
        .o_pos_z   (o_pos_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic coord_t rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        if (r < 80) return coord_t'($urandom());
        case ($urandom_range(0, 3))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic param_t rand_t();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return param_t'($urandom_range(0, 1 << TF));
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return param_t'(1 << TF);
                2: return param_t'(1);
                default: return param_t'((1 << TF) - 1);
            endcase
        end
        return param_t'($urandom_range(0, (1 << (TF + 1)) - 1));
    endfunction

    // Offer one item and hold it until the transfer; the caller sits just after an edge.
    task send_item(logic op, coord_t x, coord_t y, coord_t z, param_t t);
        int gap;
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        i_local_t <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(op, x, y, z, t);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task push_point(coord_t x, coord_t y, coord_t z);
        send_item(OPC_PUSH, x, y, z, rand_t());
    endtask

    task eval_at(param_t t);
        send_item(OPC_EVAL, rand_coord(), rand_coord(), rand_coord(), t);
    endtask

    // Drop valid and wait until every owed position has come back.
    task drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pos_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: check each transfer, then pick the stall for the next cycle.
    initial begin : receiver
        int stall_left, free_left, hold_left;
        stall_left = 0;
        free_left  = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) sb.check_result(o_pos_x, o_pos_y, o_pos_z);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (free_left > 0) free_left--;
                else begin
                    free_left  = $urandom_range(0, 30);
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles without any transfer.
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
            if (idle >= IDLE_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : sender
        coord_t px, py, pz;
        int     npush, neval;
        calm       = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: evaluate on the all-zero window, where every weight denominator is zero.
        eval_at(param_t'(1 << (TF - 1)));
        // Coincident points keep the zero-denominator case alive after pushes.
        push_point('0, '0, '0);
        eval_at('1);
        // Extremes of the coordinates, with t at zero, one, above one and its smallest step.
        push_point({1'b1, {(CW-1){1'b0}}}, {1'b0, {(CW-1){1'b1}}}, '1);
        push_point({1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}, '0);
        push_point({1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}, {1'b0, {(CW-1){1'b1}}});
        eval_at('0);
        eval_at(param_t'(1 << TF));
        eval_at('1);
        eval_at(param_t'(1));
        eval_at(param_t'((1 << TF) + 1));
        // An ordinary window of small points.
        push_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0001_8000);
        push_point(32'sh0003_0000, -32'sh0000_4000, 32'sh0000_0001);
        push_point(-32'sh0005_0000, 32'sh0004_0000, 32'sh0002_0000);
        push_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        eval_at(param_t'((1 << TF) - 1));
        eval_at(param_t'(1 << (TF - 2)));
        // Sender pauses until every owed position is back.
        drain();

        // Receiver holds off while items keep coming, so the block fills and stalls.
        hold_req = 1'b1;
        repeat (3) begin
            push_point(rand_coord(), rand_coord(), rand_coord());
            eval_at(rand_t());
        end
        drain();

        // Random: mostly whole windows followed by evaluates, some noise.
        px = '0;
        py = '0;
        pz = '0;
        while (items_sent < N_ITEMS) begin
            if ($urandom_range(0, 19) == 0) calm = ~calm;
            if ($urandom_range(0, 99) < 85) begin
                npush = $urandom_range(1, 4);
                repeat (npush) begin
                    if ($urandom_range(0, 9) != 0) begin
                        px = rand_coord();
                        py = rand_coord();
                        pz = rand_coord();
                    end
                    push_point(px, py, pz);
                end
                neval = $urandom_range(1, 2);
                repeat (neval) eval_at(rand_t());
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0) eval_at(rand_t());
                    else push_point(rand_coord(), rand_coord(), rand_coord());
                end
            end
            if ($urandom_range(0, 39) == 0) drain();
        end

        // Wind down: wait for the last positions, then a tail for anything stray.
        drain();
        repeat (EVAL_LAT) @(posedge i_clk);
        if (sb.pos_q.size() != 0) sb.report("positions never returned", 0, sb.pos_q.size());
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
